### sv/fortran_subset_tokenizer_unit_macros.svh
// assertion helpers for the tokenizer
`ifndef FORTRAN_SUBSET_TOKENIZER_UNIT_MACROS_SVH
`define FORTRAN_SUBSET_TOKENIZER_UNIT_MACROS_SVH

// property that holds at every clock outside reset
`define FSTU_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define FSTU_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### sv/fstu_pkg.sv
package fstu_pkg;

   localparam int MAX_SOURCE_BYTES = 65536;
   localparam int KEYWORD_MAX_LEN  = 10;
   localparam int KW_COUNT         = 21;
   localparam int KW_TEXT_LEN      = 10;
   localparam int DOT_COUNT        = 5;
   localparam int DOT_TEXT_LEN     = 5;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_COMMENT,
      MODE_STRING,
      MODE_NUMBER,
      MODE_IDENT,
      MODE_DOT,
      MODE_DOTWORD,
      MODE_OPER
   } lex_mode_type;

   typedef logic [5:0] kind_type;

   localparam kind_type K_INT_LIT = 6'd21;
   localparam kind_type K_STR_LIT = 6'd22;
   localparam kind_type K_IDENT   = 6'd23;
   localparam kind_type K_PLUS    = 6'd24;
   localparam kind_type K_MINUS   = 6'd25;
   localparam kind_type K_STAR    = 6'd26;
   localparam kind_type K_SLASH   = 6'd27;
   localparam kind_type K_EQ      = 6'd28;
   localparam kind_type K_NE      = 6'd29;
   localparam kind_type K_LT      = 6'd30;
   localparam kind_type K_GT      = 6'd31;
   localparam kind_type K_LE      = 6'd32;
   localparam kind_type K_GE      = 6'd33;
   localparam kind_type K_AND     = 6'd34;
   localparam kind_type K_ASSIGN  = 6'd37;
   localparam kind_type K_LPAREN  = 6'd38;
   localparam kind_type K_RPAREN  = 6'd39;
   localparam kind_type K_COMMA   = 6'd40;
   localparam kind_type K_DCOLON  = 6'd41;
   localparam kind_type K_NEWLINE = 6'd42;
   localparam kind_type K_EOF     = 6'd43;
   localparam kind_type K_ERROR   = 6'd44;

   // source characters with a meaning of their own
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   typedef struct packed {
      kind_type     kind;
      logic [15:0]  start;
      logic [15:0]  len;
      logic [15:0]  line;
      logic [30:0]  value;
      logic         ovf;
      logic [7:0]   errc;
   } token_type;

   // keyword text, space padded, first character in the top byte
   localparam logic [8*KW_TEXT_LEN-1:0] KW_TEXT [KW_COUNT] = '{
      "PROGRAM   ", "END       ", "FUNCTION  ", "SUBROUTINE", "INTEGER   ",
      "INTENT    ", "IN        ", "INOUT     ", "IF        ", "THEN      ",
      "ELSE      ", "ELSEIF    ", "DO        ", "WHILE     ", "PRINT     ",
      "READ      ", "CALL      ", "RETURN    ", "STOP      ", "EXIT      ",
      "CYCLE     "
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd7, 4'd3, 4'd8, 4'd10, 4'd7, 4'd6, 4'd2, 4'd5, 4'd2, 4'd4,
      4'd4, 4'd6, 4'd2, 4'd5, 4'd5, 4'd4, 4'd4, 4'd6, 4'd4, 4'd4, 4'd5
   };

   localparam logic [8*DOT_TEXT_LEN-1:0] DOT_TEXT [DOT_COUNT] = '{
      "AND  ", "OR   ", "NOT  ", "TRUE ", "FALSE"
   };
   localparam logic [3:0] DOT_LEN [DOT_COUNT] = '{4'd3, 4'd2, 4'd3, 4'd4, 4'd5};

   localparam int DOT_TRUE = 3;

   function automatic token_type make_tok(input kind_type kind, input logic [15:0] start,
                                          input logic [15:0] len, input logic [15:0] line,
                                          input logic [30:0] value, input logic ovf,
                                          input logic [7:0] errc);
      token_type t;
      t.kind  = kind;
      t.start = start;
      t.len   = len;
      t.line  = line;
      t.value = value;
      t.ovf   = ovf;
      t.errc  = errc;
      return t;
   endfunction

endpackage

### sv/fortran_subset_tokenizer_unit.sv
// a source word is held in the input register at acceptance and lexed there; its token
//   words are written to a two-group result buffer, which drives rsp_
// throughput: one source word per cycle unless the result buffer is full; each word
//   yields zero to three tokens, drained one per cycle while rsp_ready is high
// reset: lexer idle, position 0, line 1, result buffer empty
`include "fortran_subset_tokenizer_unit_macros.svh"

module fortran_subset_tokenizer_unit #(
   parameter int MAX_SOURCE_BYTES = fstu_pkg::MAX_SOURCE_BYTES,
   parameter int KEYWORD_MAX_LEN  = fstu_pkg::KEYWORD_MAX_LEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_token_kind,
   output logic [15:0] rsp_text_start,
   output logic [15:0] rsp_text_length,
   output logic [15:0] rsp_line_number,
   output logic [30:0] rsp_int_value,
   output logic        rsp_value_overflow,
   output logic [7:0]  rsp_error_char,
   output logic        rsp_last
);

   localparam int PW  = $clog2(MAX_SOURCE_BYTES);
   localparam int WCW = $clog2(KEYWORD_MAX_LEN + 2);
   localparam int IW  = $clog2(KEYWORD_MAX_LEN);
   localparam logic [PW-1:0]  POS_LAST = PW'(MAX_SOURCE_BYTES - 1);
   localparam logic [WCW-1:0] WC_MAX   = WCW'(KEYWORD_MAX_LEN);

   // position arithmetic modulo the source size
   function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] a);
      return (a == POS_LAST) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [PW-1:0] pos_span(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (a < b) d = d + (PW+1)'(MAX_SOURCE_BYTES);
      return d[PW-1:0];
   endfunction

   // keyword lookup over the stored letters
   function automatic fstu_pkg::kind_type ident_kind(input logic [7:0] wb [KEYWORD_MAX_LEN],
                                                     input logic [WCW-1:0] wc);
      fstu_pkg::kind_type k;
      logic hit;
      k = fstu_pkg::K_IDENT;
      for (int e = fstu_pkg::KW_COUNT - 1; e >= 0; e--) begin
         hit = (WCW'(fstu_pkg::KW_LEN[e]) == wc);
         for (int i = 0; i < fstu_pkg::KW_TEXT_LEN; i++) begin
            if ((i < int'(fstu_pkg::KW_LEN[e])) &&
                (wb[i] != fstu_pkg::KW_TEXT[e][8*(fstu_pkg::KW_TEXT_LEN-1-i) +: 8]))
               hit = 1'b0;
         end
         if (hit) k = 6'(e);
      end
      return k;
   endfunction

   // dot word lookup: {hit, index}
   function automatic logic [3:0] dot_lookup(input logic [7:0] wb [KEYWORD_MAX_LEN],
                                             input logic [WCW-1:0] wc);
      logic [3:0] r;
      logic hit;
      r = '0;
      for (int e = fstu_pkg::DOT_COUNT - 1; e >= 0; e--) begin
         hit = (WCW'(fstu_pkg::DOT_LEN[e]) == wc);
         for (int i = 0; i < fstu_pkg::DOT_TEXT_LEN; i++) begin
            if ((i < int'(fstu_pkg::DOT_LEN[e])) &&
                (wb[i] != fstu_pkg::DOT_TEXT[e][8*(fstu_pkg::DOT_TEXT_LEN-1-i) +: 8]))
               hit = 1'b0;
         end
         if (hit) r = {1'b1, 3'(e)};
      end
      return r;
   endfunction

   // single operator left pending when no second character joins it
   function automatic fstu_pkg::token_type oper_flush(input logic [7:0] h,
                                                      input logic [15:0] st,
                                                      input logic [15:0] ln);
      fstu_pkg::kind_type k;
      logic [7:0] e;
      e = 8'd0;
      unique case (h)
         fstu_pkg::CH_EQUAL: k = fstu_pkg::K_ASSIGN;
         fstu_pkg::CH_SLASH: k = fstu_pkg::K_SLASH;
         fstu_pkg::CH_LT:    k = fstu_pkg::K_LT;
         fstu_pkg::CH_GT:    k = fstu_pkg::K_GT;
         default: begin
            k = fstu_pkg::K_ERROR;
            e = h;
         end
      endcase
      return fstu_pkg::make_tok(k, st, 16'd1, ln, 31'd0, 1'b0, e);
   endfunction

   // input register
   logic       in_valid_ff;
   logic       in_op_ff;
   logic [7:0] in_char_ff;
   logic       process;

   // lexer state
   fstu_pkg::lex_mode_type mode_ff, mode_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic [15:0]    line_ff, line_in;
   logic [PW-1:0]  tb_ff, tb_in;
   logic [15:0]    tbl_ff, tbl_in;
   logic [30:0]    acc_ff, acc_in;
   logic           sat_ff, sat_in;
   logic [7:0]     wbuf_ff [KEYWORD_MAX_LEN];
   logic [7:0]     wbuf_in [KEYWORD_MAX_LEN];
   logic [WCW-1:0] wc_ff, wc_in;
   logic [7:0]     quote_ff, quote_in;
   logic [7:0]     held_ff, held_in;

   // tokens of the word being lexed
   fstu_pkg::token_type tok_in [3];
   logic [1:0]          tok_n;

   // result buffer: two groups of up to three tokens
   fstu_pkg::token_type grp_tok_ff [2][3];
   logic [1:0]          grp_n_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          grp_cnt_ff;
   logic [1:0]          sub_ff;
   logic                push;
   logic                pop;
   fstu_pkg::token_type head_tok;

   assign process   = in_valid_ff && (grp_cnt_ff != 2'd2);
   assign req_ready = !in_valid_ff || process;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_op_ff   <= req_op;
         in_char_ff <= req_char_in;
      end
   end

   // lexer step for the registered word
   always_comb begin
      logic [7:0]  c;
      logic [7:0]  lc;
      logic        cont;
      logic [34:0] prod;
      logic [3:0]  dres;
      fstu_pkg::kind_type k;

      c        = in_char_ff;
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      line_in  = line_ff;
      tb_in    = tb_ff;
      tbl_in   = tbl_ff;
      acc_in   = acc_ff;
      sat_in   = sat_ff;
      wbuf_in  = wbuf_ff;
      wc_in    = wc_ff;
      quote_in = quote_ff;
      held_in  = held_ff;
      tok_n    = 2'd0;
      for (int t = 0; t < 3; t++) tok_in[t] = '0;
      lc       = ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
      cont     = !in_op_ff;
      prod     = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + 35'(c - fstu_pkg::CH_ZERO);
      dres     = dot_lookup(wbuf_ff, wc_ff);
      k        = '0;

      if (in_op_ff) begin
         // end of source: flush the pending token, then end marker
         unique case (mode_in)
            fstu_pkg::MODE_STRING: begin
               tok_in[tok_n] = fstu_pkg::make_tok(fstu_pkg::K_STR_LIT, 16'(tb_in),
                  16'(pos_span(pos_in, tb_in)), tbl_in, 31'd0, 1'b0, 8'd0);
               tok_n = tok_n + 2'd1;
            end
            fstu_pkg::MODE_NUMBER: begin
               tok_in[tok_n] = fstu_pkg::make_tok(fstu_pkg::K_INT_LIT, 16'(tb_in),
                  16'(pos_span(pos_in, tb_in)), tbl_in, acc_in, sat_in, 8'd0);
               tok_n = tok_n + 2'd1;
            end
            fstu_pkg::MODE_IDENT: begin
               tok_in[tok_n] = fstu_pkg::make_tok(ident_kind(wbuf_in, wc_in), 16'(tb_in),
                  16'(pos_span(pos_in, tb_in)), tbl_in, 31'd0, 1'b0, 8'd0);
               tok_n = tok_n + 2'd1;
            end
            fstu_pkg::MODE_DOT: begin
               tok_in[tok_n] = fstu_pkg::make_tok(fstu_pkg::K_ERROR, 16'(tb_in), 16'd1,
                  tbl_in, 31'd0, 1'b0, fstu_pkg::CH_DOT);
               tok_n = tok_n + 2'd1;
            end
            fstu_pkg::MODE_DOTWORD: begin
               tok_in[tok_n] = fstu_pkg::make_tok(fstu_pkg::K_ERROR, 16'(tb_in), 16'd1,
                  tbl_in, 31'd0, 1'b0, fstu_pkg::CH_DOT);
               tok_n = tok_n + 2'd1;
               tb_in = pos_inc(tb_in);
               tok_in[tok_n] = fstu_pkg::make_tok(ident_kind(wbuf_in, wc_in), 16'(tb_in),
                  16'(pos_span(pos_in, tb_in)), tbl_in, 31'd0, 1'b0, 8'd0);
               tok_n = tok_n + 2'd1;
            end
            fstu_pkg::MODE_OPER: begin
               tok_in[tok_n] = oper_flush(held_in, 16'(tb_in), tbl_in);
               tok_n = tok_n + 2'd1;
            end
            default: begin
            end
         endcase
         mode_in = fstu_pkg::MODE_IDLE;
         tok_in[tok_n] = fstu_pkg::make_tok(fstu_pkg::K_EOF, 16'(pos_in), 16'd0, line_in,
            31'd0, 1'b0, 8'd0);
         tok_n = tok_n + 2'd1;
      end

      // a character may close a token and be lexed again in the mode that follows
      for (int g = 0; g < 4; g++) begin
         if (cont) begin
            cont = 1'b0;
            unique case (mode_in)
               fstu_pkg::MODE_COMMENT: begin
                  if (c == fstu_pkg::CH_LF) begin
                     mode_in = fstu_pkg::MODE_IDLE;
                     cont    = 1'b1;
                  end else begin
                     pos_in = pos_inc(pos_in);
                  end
               end
               fstu_pkg::MODE_STRING: begin
                  if ((c == quote_in) || (c == fstu_pkg::CH_LF)) begin
                     tok_in[tok_n] = fstu_pkg::make_tok(fstu_pkg::K_STR_LIT, 16'(tb_in),
                        16'(pos_span(pos_in, tb_in)), tbl_in, 31'd0, 1'b0, 8'd0);
                     tok_n   = tok_n + 2'd1;
                     mode_in = fstu_pkg::MODE_IDLE;
                     if (c == fstu_pkg::CH_LF) cont = 1'b1;
                     else pos_in = pos_inc(pos_in);
                  end else begin
                     pos_in = pos_inc(pos_in);
                     if (c == fstu_pkg::CH_LF) line_in = line_in + 16'd1;
                  end
               end
               fstu_pkg::MODE_NUMBER: begin
                  if ((c >= fstu_pkg::CH_ZERO) && (c <= 8'h39)) begin
                     if (prod > 35'h7FFF_FFFF) begin
                        acc_in = 31'h7FFF_FFFF;
                        sat_in = 1'b1;
                     end else begin
                        acc_in = prod[30:0];
                     end
                     pos_in = pos_inc(pos_in);
                  end else begin
                     tok_in[tok_n] = fstu_pkg::make_tok(fstu_pkg::K_INT_LIT, 16'(tb_in),
                        16'(pos_span(pos_in, tb_in)), tbl_in, acc_in, sat_in, 8'd0);
                     tok_n   = tok_n + 2'd1;
                     mode_in = fstu_pkg::MODE_IDLE;
                     cont    = 1'b1;
                  end
               end
               fstu_pkg::MODE_IDENT: begin
                  if (((lc >= 8'h41) && (lc <= 8'h5A)) || ((c >= fstu_pkg::CH_ZERO) &&
                      (c <= 8'h39)) || (c == fstu_pkg::CH_UNDER)) begin
                     if (wc_in < WC_MAX) wbuf_in[wc_in[IW-1:0]] = lc;
                     if (wc_in <= WC_MAX) wc_in = wc_in + 1'b1;
                     pos_in = pos_inc(pos_in);
                  end else begin
                     tok_in[tok_n] = fstu_pkg::make_tok(ident_kind(wbuf_in, wc_in),
                        16'(tb_in), 16'(pos_span(pos_in, tb_in)), tbl_in, 31'd0, 1'b0, 8'd0);
                     tok_n   = tok_n + 2'd1;
                     mode_in = fstu_pkg::MODE_IDLE;
                     cont    = 1'b1;
                  end
               end
               fstu_pkg::MODE_DOT, fstu_pkg::MODE_DOTWORD: begin
                  if ((lc >= 8'h41) && (lc <= 8'h5A)) begin
                     if (wc_in < WC_MAX) wbuf_in[wc_in[IW-1:0]] = lc;
                     if (wc_in <= WC_MAX) wc_in = wc_in + 1'b1;
                     mode_in = fstu_pkg::MODE_DOTWORD;
                     pos_in  = pos_inc(pos_in);
                  end else if ((mode_in == fstu_pkg::MODE_DOTWORD) &&
                               (c == fstu_pkg::CH_DOT) && dres[3]) begin
                     // known dot word closed by its second dot
                     if (int'(dres[2:0]) < fstu_pkg::DOT_TRUE) begin
                        tok_in[tok_n] = fstu_pkg::make_tok(fstu_pkg::K_AND + 6'(dres[2:0]),
                           16'(tb_in), 16'(pos_span(pos_in, tb_in)) + 16'd1, tbl_in,
                           31'd0, 1'b0, 8'd0);
                     end else begin
                        tok_in[tok_n] = fstu_pkg::make_tok(fstu_pkg::K_INT_LIT,
                           16'(tb_in), 16'(pos_span(pos_in, tb_in)) + 16'd1, tbl_in,
                           {30'd0, (int'(dres[2:0]) == fstu_pkg::DOT_TRUE)}, 1'b0, 8'd0);
                     end
                     tok_n   = tok_n + 2'd1;
                     mode_in = fstu_pkg::MODE_IDLE;
                     pos_in  = pos_inc(pos_in);
                  end else begin
                     tok_in[tok_n] = fstu_pkg::make_tok(fstu_pkg::K_ERROR, 16'(tb_in),
                        16'd1, tbl_in, 31'd0, 1'b0, fstu_pkg::CH_DOT);
                     tok_n = tok_n + 2'd1;
                     if (mode_in == fstu_pkg::MODE_DOTWORD) begin
                        // failed dot word: letters relexed as an identifier
                        tb_in   = pos_inc(tb_in);
                        mode_in = fstu_pkg::MODE_IDENT;
                     end else begin
                        mode_in = fstu_pkg::MODE_IDLE;
                     end
                     cont = 1'b1;
                  end
               end
               fstu_pkg::MODE_OPER: begin
                  k = '0;
                  if ((held_in == fstu_pkg::CH_COLON) && (c == fstu_pkg::CH_COLON))
                     k = fstu_pkg::K_DCOLON;
                  else if (c == fstu_pkg::CH_EQUAL) begin
                     unique case (held_in)
                        fstu_pkg::CH_EQUAL: k = fstu_pkg::K_EQ;
                        fstu_pkg::CH_SLASH: k = fstu_pkg::K_NE;
                        fstu_pkg::CH_LT:    k = fstu_pkg::K_LE;
                        fstu_pkg::CH_GT:    k = fstu_pkg::K_GE;
                        default:            k = '0;
                     endcase
                  end
                  if (k != '0) begin
                     tok_in[tok_n] = fstu_pkg::make_tok(k, 16'(tb_in), 16'd2, tbl_in,
                        31'd0, 1'b0, 8'd0);
                     tok_n   = tok_n + 2'd1;
                     mode_in = fstu_pkg::MODE_IDLE;
                     pos_in  = pos_inc(pos_in);
                  end else begin
                     tok_in[tok_n] = oper_flush(held_in, 16'(tb_in), tbl_in);
                     tok_n   = tok_n + 2'd1;
                     mode_in = fstu_pkg::MODE_IDLE;
                     cont    = 1'b1;
                  end
               end
               default: begin
                  // idle: start of a new token
                  mode_in = fstu_pkg::MODE_IDLE;
                  k       = '0;
                  unique case (c)
                     fstu_pkg::CH_SPACE, fstu_pkg::CH_TAB, fstu_pkg::CH_CR: begin
                     end
                     fstu_pkg::CH_LF, fstu_pkg::CH_SEMI: begin
                        tok_in[tok_n] = fstu_pkg::make_tok(fstu_pkg::K_NEWLINE, 16'(pos_in),
                           16'd1, line_in, 31'd0, 1'b0, 8'd0);
                        tok_n = tok_n + 2'd1;
                     end
                     fstu_pkg::CH_BANG: mode_in = fstu_pkg::MODE_COMMENT;
                     fstu_pkg::CH_DQUOTE, fstu_pkg::CH_SQUOTE: begin
                        quote_in = c;
                        tbl_in   = line_in;
                        tb_in    = pos_inc(pos_in);
                        mode_in  = fstu_pkg::MODE_STRING;
                     end
                     fstu_pkg::CH_DOT: begin
                        tb_in   = pos_in;
                        tbl_in  = line_in;
                        wc_in   = '0;
                        mode_in = fstu_pkg::MODE_DOT;
                     end
                     fstu_pkg::CH_COLON, fstu_pkg::CH_EQUAL, fstu_pkg::CH_SLASH,
                     fstu_pkg::CH_LT, fstu_pkg::CH_GT: begin
                        tb_in   = pos_in;
                        tbl_in  = line_in;
                        held_in = c;
                        mode_in = fstu_pkg::MODE_OPER;
                     end
                     fstu_pkg::CH_PLUS:   k = fstu_pkg::K_PLUS;
                     fstu_pkg::CH_MINUS:  k = fstu_pkg::K_MINUS;
                     fstu_pkg::CH_STAR:   k = fstu_pkg::K_STAR;
                     fstu_pkg::CH_LPAREN: k = fstu_pkg::K_LPAREN;
                     fstu_pkg::CH_RPAREN: k = fstu_pkg::K_RPAREN;
                     fstu_pkg::CH_COMMA:  k = fstu_pkg::K_COMMA;
                     default: begin
                        if ((c >= fstu_pkg::CH_ZERO) && (c <= 8'h39)) begin
                           tb_in   = pos_in;
                           tbl_in  = line_in;
                           acc_in  = 31'(c - fstu_pkg::CH_ZERO);
                           sat_in  = 1'b0;
                           mode_in = fstu_pkg::MODE_NUMBER;
                        end else if (((lc >= 8'h41) && (lc <= 8'h5A)) ||
                                     (c == fstu_pkg::CH_UNDER)) begin
                           tb_in      = pos_in;
                           tbl_in     = line_in;
                           wbuf_in[0] = lc;
                           wc_in      = WCW'(1);
                           mode_in    = fstu_pkg::MODE_IDENT;
                        end else begin
                           k = fstu_pkg::K_ERROR;
                        end
                     end
                  endcase
                  if (k != '0) begin
                     tok_in[tok_n] = fstu_pkg::make_tok(k, 16'(pos_in), 16'd1, line_in,
                        31'd0, 1'b0, (k == fstu_pkg::K_ERROR) ? c : 8'd0);
                     tok_n = tok_n + 2'd1;
                  end
                  pos_in = pos_inc(pos_in);
                  if (c == fstu_pkg::CH_LF) line_in = line_in + 16'd1;
               end
            endcase
         end
      end
   end

   // lexer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= fstu_pkg::MODE_IDLE;
         pos_ff   <= '0;
         line_ff  <= 16'd1;
         tb_ff    <= '0;
         tbl_ff   <= 16'd1;
         acc_ff   <= '0;
         sat_ff   <= 1'b0;
         wc_ff    <= '0;
         quote_ff <= '0;
         held_ff  <= '0;
      end else if (process) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
         tb_ff    <= tb_in;
         tbl_ff   <= tbl_in;
         acc_ff   <= acc_in;
         sat_ff   <= sat_in;
         wc_ff    <= wc_in;
         quote_ff <= quote_in;
         held_ff  <= held_in;
      end
      if (process) wbuf_ff <= wbuf_in;
   end

   // result buffer
   assign push     = process && (tok_n != 2'd0);
   assign head_tok = grp_tok_ff[rd_ptr_ff][sub_ff];
   assign rsp_valid = (grp_cnt_ff != 2'd0);
   assign rsp_last  = (sub_ff == (grp_n_ff[rd_ptr_ff] - 2'd1));
   assign pop       = rsp_valid && rsp_ready && rsp_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         grp_cnt_ff <= 2'd0;
         sub_ff     <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) grp_cnt_ff <= grp_cnt_ff + 2'd1;
         else if (pop && !push) grp_cnt_ff <= grp_cnt_ff - 2'd1;
         if (rsp_valid && rsp_ready) sub_ff <= rsp_last ? 2'd0 : sub_ff + 2'd1;
      end
      if (push) begin
         grp_tok_ff[wr_ptr_ff] <= tok_in;
         grp_n_ff[wr_ptr_ff]   <= tok_n;
      end
   end

   // result word fields
   assign rsp_token_kind     = head_tok.kind;
   assign rsp_text_start     = head_tok.start;
   assign rsp_text_length    = head_tok.len;
   assign rsp_line_number    = head_tok.line;
   assign rsp_int_value      = head_tok.value;
   assign rsp_value_overflow = head_tok.ovf;
   assign rsp_error_char     = head_tok.errc;

   // checks
   `FSTU_ASSERT(a_grp_cnt_range, grp_cnt_ff != 2'd3, "result buffer count out of range")
   `FSTU_ASSERT(a_sub_in_group, (grp_cnt_ff != 2'd0) |-> (sub_ff < grp_n_ff[rd_ptr_ff]), "token index past group")
   `FSTU_ASSERT_NEXT(a_eos_gives_result, process && in_op_ff, grp_cnt_ff != 2'd0, "end of source left no result")
   `FSTU_ASSERT(a_pos_range, pos_ff <= POS_LAST, "position past source size")

endmodule

### bench/fortran_subset_tokenizer_unit_tb.sv
module fortran_subset_tokenizer_unit_tb;

   localparam int PERIOD     = 12;
   localparam int RAND_WORDS = 365;
   localparam int WORD_MAX   = 10;
   localparam int TAIL       = 20;

   // one source word for the driver
   typedef struct {
      logic       op;
      logic [7:0] ch;
      bit         drain;
   } source_word_type;

   // one token word as seen on rsp_
   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic [30:0] value;
      logic        ovf;
      logic [7:0]  errc;
      logic        last;
   } token_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = 1'b0;
   logic [7:0]  req_char_in = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [15:0] rsp_text_start;
   logic [15:0] rsp_text_length;
   logic [15:0] rsp_line_number;
   logic [30:0] rsp_int_value;
   logic        rsp_value_overflow;
   logic [7:0]  rsp_error_char;
   logic        rsp_last;

   source_word_type source_words[$];
   token_word_type  expected_tokens[$];
   token_word_type  step_tokens[$];

   int mismatches = 0;
   int tokens_checked = 0;
   int words_sent = 0;
   int eos_sent = 0;
   int send_gap = 0;
   int recv_gap = 0;
   bit send_burst = 0;
   bit recv_burst = 0;

   // lexer state of the predictor
   fstu_pkg::lex_mode_type mode = fstu_pkg::MODE_IDLE;
   logic [15:0] pos = 16'd0;
   logic [15:0] cur_line = 16'd1;
   logic [15:0] tok_begin = 16'd0;
   logic [15:0] tok_line = 16'd1;
   logic [30:0] acc = 31'd0;
   logic        sat = 1'b0;
   logic [7:0]  wbuf [WORD_MAX];
   int          wcount = 0;
   logic [7:0]  quote = 8'd0;
   logic [7:0]  held = 8'd0;

   string KEYWORDS [21] = '{"PROGRAM", "END", "FUNCTION", "SUBROUTINE", "INTEGER",
      "INTENT", "IN", "INOUT", "IF", "THEN", "ELSE", "ELSEIF", "DO", "WHILE", "PRINT",
      "READ", "CALL", "RETURN", "STOP", "EXIT", "CYCLE"};
   string DOT_WORDS [5] = '{"AND", "OR", "NOT", "TRUE", "FALSE"};
   string OPERATORS [16] = '{"+", "-", "*", "(", ")", ",", "::", ":", "==", "/=", "<=",
      ">=", "=", "/", "<", ">"};

   fortran_subset_tokenizer_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_char_in(req_char_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_token_kind(rsp_token_kind),
      .rsp_text_start(rsp_text_start), .rsp_text_length(rsp_text_length),
      .rsp_line_number(rsp_line_number), .rsp_int_value(rsp_int_value),
      .rsp_value_overflow(rsp_value_overflow), .rsp_error_char(rsp_error_char),
      .rsp_last(rsp_last)
   );

   always #(PERIOD / 2) clock = ~clock;

   // character classes
   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == fstu_pkg::CH_UNDER;
   endfunction

   function automatic void push_token(input logic [5:0] kind, input logic [15:0] start,
                                      input logic [15:0] len, input logic [15:0] line,
                                      input logic [30:0] value, input logic ovf,
                                      input logic [7:0] errc);
      token_word_type t;
      t = '{kind, start, len, line, value, ovf, errc, 1'b0};
      if (step_tokens.size() < 3) step_tokens.push_back(t);
   endfunction

   function automatic logic [15:0] span();
      return pos - tok_begin;
   endfunction

   function automatic void advance(input logic [7:0] c);
      pos = pos + 16'd1;
      if (c == fstu_pkg::CH_LF) cur_line = cur_line + 16'd1;
   endfunction

   function automatic void mark_begin();
      tok_begin = pos;
      tok_line = cur_line;
   endfunction

   function automatic void add_letter(input logic [7:0] c);
      logic [7:0] u;
      u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
      if (wcount < WORD_MAX) wbuf[wcount] = u;
      if (wcount <= WORD_MAX) wcount++;
   endfunction

   // index of the buffered word in a table, -1 when absent
   function automatic int lookup_word(input bit dots);
      int n;
      string s;
      bit same;
      n = dots ? 5 : 21;
      if (wcount > WORD_MAX) return -1;
      for (int i = 0; i < n; i++) begin
         s = dots ? DOT_WORDS[i] : KEYWORDS[i];
         if (s.len() == wcount) begin
            same = 1;
            for (int j = 0; j < wcount; j++)
               if (wbuf[j] != s[j]) same = 0;
            if (same) return i;
         end
      end
      return -1;
   endfunction

   function automatic void close_ident();
      int k;
      k = lookup_word(0);
      push_token(k < 0 ? fstu_pkg::K_IDENT : 6'(k), tok_begin, span(), tok_line, 31'd0,
                 1'b0, 8'd0);
   endfunction

   // bad dot word: error at the dot, letters become an identifier
   function automatic void dot_failed();
      push_token(fstu_pkg::K_ERROR, tok_begin, 16'd1, tok_line, 31'd0, 1'b0,
                 fstu_pkg::CH_DOT);
      tok_begin = tok_begin + 16'd1;
      mode = fstu_pkg::MODE_IDENT;
   endfunction

   function automatic void flush_held();
      logic [5:0] k;
      case (held)
         fstu_pkg::CH_EQUAL: k = fstu_pkg::K_ASSIGN;
         fstu_pkg::CH_SLASH: k = fstu_pkg::K_SLASH;
         fstu_pkg::CH_LT:    k = fstu_pkg::K_LT;
         fstu_pkg::CH_GT:    k = fstu_pkg::K_GT;
         default: begin
            push_token(fstu_pkg::K_ERROR, tok_begin, 16'd1, tok_line, 31'd0, 1'b0, held);
            return;
         end
      endcase
      push_token(k, tok_begin, 16'd1, tok_line, 31'd0, 1'b0, 8'd0);
   endfunction

   function automatic void lex_idle(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         fstu_pkg::CH_SPACE, fstu_pkg::CH_TAB, fstu_pkg::CH_CR: begin
            advance(c);
            return;
         end
         fstu_pkg::CH_LF, fstu_pkg::CH_SEMI: begin
            push_token(fstu_pkg::K_NEWLINE, pos, 16'd1, cur_line, 31'd0, 1'b0, 8'd0);
            advance(c);
            return;
         end
         fstu_pkg::CH_BANG: begin
            mode = fstu_pkg::MODE_COMMENT;
            advance(c);
            return;
         end
         fstu_pkg::CH_DQUOTE, fstu_pkg::CH_SQUOTE: begin
            quote = c;
            tok_line = cur_line;
            advance(c);
            tok_begin = pos;
            mode = fstu_pkg::MODE_STRING;
            return;
         end
         fstu_pkg::CH_DOT: begin
            mark_begin();
            wcount = 0;
            mode = fstu_pkg::MODE_DOT;
            advance(c);
            return;
         end
         fstu_pkg::CH_COLON, fstu_pkg::CH_EQUAL, fstu_pkg::CH_SLASH, fstu_pkg::CH_LT,
         fstu_pkg::CH_GT: begin
            mark_begin();
            held = c;
            mode = fstu_pkg::MODE_OPER;
            advance(c);
            return;
         end
         fstu_pkg::CH_PLUS:   k = fstu_pkg::K_PLUS;
         fstu_pkg::CH_MINUS:  k = fstu_pkg::K_MINUS;
         fstu_pkg::CH_STAR:   k = fstu_pkg::K_STAR;
         fstu_pkg::CH_LPAREN: k = fstu_pkg::K_LPAREN;
         fstu_pkg::CH_RPAREN: k = fstu_pkg::K_RPAREN;
         fstu_pkg::CH_COMMA:  k = fstu_pkg::K_COMMA;
         default: begin
            if (is_digit(c)) begin
               mark_begin();
               acc = 31'(c - fstu_pkg::CH_ZERO);
               sat = 1'b0;
               mode = fstu_pkg::MODE_NUMBER;
            end else if (is_alpha(c) || c == fstu_pkg::CH_UNDER) begin
               mark_begin();
               wcount = 0;
               add_letter(c);
               mode = fstu_pkg::MODE_IDENT;
            end else begin
               push_token(fstu_pkg::K_ERROR, pos, 16'd1, cur_line, 31'd0, 1'b0, c);
            end
            advance(c);
            return;
         end
      endcase
      push_token(k, pos, 16'd1, cur_line, 31'd0, 1'b0, 8'd0);
      advance(c);
   endfunction

   // one source character; a closing character is looked at again in the mode that follows
   function automatic void lex_char(input logic [7:0] c);
      bit again;
      longint v;
      int d;
      logic [5:0] k;
      again = 1;
      for (int g = 0; g < 4 && again; g++) begin
         again = 0;
         case (mode)
            fstu_pkg::MODE_COMMENT: begin
               if (c == fstu_pkg::CH_LF) begin
                  mode = fstu_pkg::MODE_IDLE;
                  again = 1;
               end else advance(c);
            end
            fstu_pkg::MODE_STRING: begin
               if (c == quote || c == fstu_pkg::CH_LF) begin
                  push_token(fstu_pkg::K_STR_LIT, tok_begin, span(), tok_line, 31'd0,
                             1'b0, 8'd0);
                  mode = fstu_pkg::MODE_IDLE;
                  if (c == fstu_pkg::CH_LF) again = 1;
                  else advance(c);
               end else advance(c);
            end
            fstu_pkg::MODE_NUMBER: begin
               if (is_digit(c)) begin
                  v = longint'(acc) * 10 + longint'(c - fstu_pkg::CH_ZERO);
                  if (v > 64'h7FFFFFFF) begin
                     v = 64'h7FFFFFFF;
                     sat = 1'b1;
                  end
                  acc = 31'(v);
                  advance(c);
               end else begin
                  push_token(fstu_pkg::K_INT_LIT, tok_begin, span(), tok_line, acc, sat,
                             8'd0);
                  mode = fstu_pkg::MODE_IDLE;
                  again = 1;
               end
            end
            fstu_pkg::MODE_IDENT: begin
               if (is_word(c)) begin
                  add_letter(c);
                  advance(c);
               end else begin
                  close_ident();
                  mode = fstu_pkg::MODE_IDLE;
                  again = 1;
               end
            end
            fstu_pkg::MODE_DOT: begin
               if (is_alpha(c)) begin
                  add_letter(c);
                  mode = fstu_pkg::MODE_DOTWORD;
                  advance(c);
               end else begin
                  push_token(fstu_pkg::K_ERROR, tok_begin, 16'd1, tok_line, 31'd0, 1'b0,
                             fstu_pkg::CH_DOT);
                  mode = fstu_pkg::MODE_IDLE;
                  again = 1;
               end
            end
            fstu_pkg::MODE_DOTWORD: begin
               d = (c == fstu_pkg::CH_DOT) ? lookup_word(1) : -1;
               if (is_alpha(c)) begin
                  add_letter(c);
                  advance(c);
               end else if (d >= 0) begin
                  if (d < fstu_pkg::DOT_TRUE)
                     push_token(fstu_pkg::K_AND + 6'(d), tok_begin, span() + 16'd1,
                                tok_line, 31'd0, 1'b0, 8'd0);
                  else
                     push_token(fstu_pkg::K_INT_LIT, tok_begin, span() + 16'd1, tok_line,
                                (d == fstu_pkg::DOT_TRUE) ? 31'd1 : 31'd0, 1'b0, 8'd0);
                  mode = fstu_pkg::MODE_IDLE;
                  advance(c);
               end else begin
                  dot_failed();
                  again = 1;
               end
            end
            fstu_pkg::MODE_OPER: begin
               k = 6'd0;
               if (held == fstu_pkg::CH_COLON && c == fstu_pkg::CH_COLON)
                  k = fstu_pkg::K_DCOLON;
               else if (c == fstu_pkg::CH_EQUAL) begin
                  case (held)
                     fstu_pkg::CH_EQUAL: k = fstu_pkg::K_EQ;
                     fstu_pkg::CH_SLASH: k = fstu_pkg::K_NE;
                     fstu_pkg::CH_LT:    k = fstu_pkg::K_LE;
                     fstu_pkg::CH_GT:    k = fstu_pkg::K_GE;
                     default:            k = 6'd0;
                  endcase
               end
               if (k != 6'd0) begin
                  push_token(k, tok_begin, 16'd2, tok_line, 31'd0, 1'b0, 8'd0);
                  mode = fstu_pkg::MODE_IDLE;
                  advance(c);
               end else begin
                  flush_held();
                  mode = fstu_pkg::MODE_IDLE;
                  again = 1;
               end
            end
            default: begin
               mode = fstu_pkg::MODE_IDLE;
               lex_idle(c);
            end
         endcase
      end
   endfunction

   function automatic void lex_end_of_source();
      case (mode)
         fstu_pkg::MODE_STRING:
            push_token(fstu_pkg::K_STR_LIT, tok_begin, span(), tok_line, 31'd0, 1'b0,
                       8'd0);
         fstu_pkg::MODE_NUMBER:
            push_token(fstu_pkg::K_INT_LIT, tok_begin, span(), tok_line, acc, sat, 8'd0);
         fstu_pkg::MODE_IDENT: close_ident();
         fstu_pkg::MODE_DOT:
            push_token(fstu_pkg::K_ERROR, tok_begin, 16'd1, tok_line, 31'd0, 1'b0,
                       fstu_pkg::CH_DOT);
         fstu_pkg::MODE_DOTWORD: begin
            dot_failed();
            close_ident();
         end
         fstu_pkg::MODE_OPER: flush_held();
         default: ;
      endcase
      mode = fstu_pkg::MODE_IDLE;
      push_token(fstu_pkg::K_EOF, pos, 16'd0, cur_line, 31'd0, 1'b0, 8'd0);
   endfunction

   // tokens caused by one accepted source word
   function automatic void predict_tokens(input source_word_type w);
      step_tokens.delete();
      if (w.op) lex_end_of_source();
      else lex_char(w.ch);
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   // mostly short gaps, a few long ones, none inside a burst
   function automatic int pick_gap(input bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void push_char(input logic [7:0] c);
      source_words.push_back('{1'b0, c, 1'b0});
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endfunction

   function automatic void push_eos();
      source_words.push_back('{1'b1, 8'($urandom_range(0, 255)), 1'b0});
   endfunction

   function automatic logic [7:0] mixed_case(input logic [7:0] c);
      return $urandom_range(0, 1) ? (c | 8'h20) : c;
   endfunction

   // one random fragment of source text
   function automatic void push_fragment();
      string s;
      int n;
      logic [7:0] q;
      case ($urandom_range(0, 11))
         0: begin
            s = KEYWORDS[$urandom_range(0, 20)];
            for (int i = 0; i < s.len(); i++) push_char(mixed_case(s[i]));
         end
         1: begin
            n = $urandom_range(1, 14);
            push_char($urandom_range(0, 5) == 0 ? fstu_pkg::CH_UNDER :
                      mixed_case(8'($urandom_range(65, 90))));
            for (int i = 1; i < n; i++)
               case ($urandom_range(0, 3))
                  0: push_char(8'($urandom_range(48, 57)));
                  1: push_char(fstu_pkg::CH_UNDER);
                  default: push_char(mixed_case(8'($urandom_range(65, 90))));
               endcase
         end
         2: begin
            n = $urandom_range(0, 3) == 0 ? $urandom_range(9, 13) : $urandom_range(1, 4);
            for (int i = 0; i < n; i++) push_char(8'($urandom_range(48, 57)));
         end
         3: begin
            s = DOT_WORDS[$urandom_range(0, 4)];
            push_char(fstu_pkg::CH_DOT);
            for (int i = 0; i < s.len(); i++) push_char(mixed_case(s[i]));
            push_char(fstu_pkg::CH_DOT);
         end
         4: begin
            push_char(fstu_pkg::CH_DOT);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) push_char(mixed_case(8'($urandom_range(65, 90))));
            case ($urandom_range(0, 2))
               0: push_char(fstu_pkg::CH_DOT);
               1: push_char(fstu_pkg::CH_SPACE);
               default: ;
            endcase
         end
         5: push_text(OPERATORS[$urandom_range(0, 15)]);
         6: begin
            q = $urandom_range(0, 1) ? fstu_pkg::CH_DQUOTE : fstu_pkg::CH_SQUOTE;
            push_char(q);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) push_char(8'($urandom_range(32, 126)));
            case ($urandom_range(0, 3))
               0: push_char(fstu_pkg::CH_LF);
               1: ;
               default: push_char(q);
            endcase
         end
         7: begin
            push_char(fstu_pkg::CH_BANG);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)));
            push_char(fstu_pkg::CH_LF);
         end
         8: begin
            case ($urandom_range(0, 2))
               0: push_char(fstu_pkg::CH_TAB);
               1: push_char(fstu_pkg::CH_CR);
               default: push_char(fstu_pkg::CH_SPACE);
            endcase
         end
         9: push_char($urandom_range(0, 1) ? fstu_pkg::CH_LF : fstu_pkg::CH_SEMI);
         10: push_char(8'($urandom_range(0, 255)));
         default: begin
            if ($urandom_range(0, 3) == 0) push_eos();
            else push_char(fstu_pkg::CH_SPACE);
         end
      endcase
      if ($urandom_range(0, 2) == 0) push_char(fstu_pkg::CH_SPACE);
   endfunction

   // driver: offers source words, runs the predictor on acceptance
   always @(posedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_tokens(source_words.pop_front());
            words_sent++;
            if (req_op) eos_sent++;
            next_valid = 1'b0;
            if ($urandom_range(0, 49) == 0) send_burst = ~send_burst;
            send_gap = pick_gap(send_burst);
         end
         if (!next_valid) begin
            if (send_gap > 0) send_gap--;
            else if (source_words.size() > 0 &&
                     !(source_words[0].drain && expected_tokens.size() > 0)) begin
               next_valid = 1'b1;
               req_op <= source_words[0].op;
               req_char_in <= source_words[0].ch;
            end
         end
      end
      req_valid <= next_valid;
   end

   task automatic report_mismatch(input string what, input token_word_type e,
                                  input token_word_type g);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch (%s)", what);
         $display("  expected kind %0d start %0d len %0d line %0d val %0d ovf %0b err %0h last %0b",
                  e.kind, e.start, e.len, e.line, e.value, e.ovf, e.errc, e.last);
         $display("  got      kind %0d start %0d len %0d line %0d val %0d ovf %0b err %0h last %0b",
                  g.kind, g.start, g.len, g.line, g.value, g.ovf, g.errc, g.last);
      end
   endtask

   // monitor: checks token words, stalls rsp_ready at random
   always @(posedge clock) begin
      token_word_type got;
      token_word_type exp_tok;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_token_kind, rsp_text_start, rsp_text_length, rsp_line_number,
                    rsp_int_value, rsp_value_overflow, rsp_error_char, rsp_last};
            if (expected_tokens.size() == 0) begin
               report_mismatch("no token expected", '0, got);
            end else begin
               exp_tok = expected_tokens.pop_front();
               tokens_checked++;
               if (got !== exp_tok) report_mismatch("field", exp_tok, got);
            end
            if ($urandom_range(0, 49) == 0) recv_burst = ~recv_burst;
            recv_gap = pick_gap(recv_burst);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int target;
      bit drain_set;
      // directed: keyword, dot word, bad dot, overflow, pair, lone colon,
      // comment, unknown bytes, unterminated string, double end of source
      push_text("SUBROUTINE .TRUE..q 99999999999 /=:!c");
      push_char(fstu_pkg::CH_LF);
      push_char(8'hFF);
      push_char(8'h00);
      push_text("'s");
      push_eos();
      push_eos();
      target = source_words.size() + RAND_WORDS;
      drain_set = 0;
      while (source_words.size() < target) begin
         if (!drain_set && source_words.size() > target / 2) begin
            source_words[source_words.size() - 1].drain = 1;
            drain_set = 1;
         end
         push_fragment();
      end
      push_eos();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (source_words.size() == 0 && !req_valid);
      wait (expected_tokens.size() == 0);
      repeat (TAIL) @(posedge clock);
      if (expected_tokens.size() > 0) mismatches++;

      $display("sent %0d source words (%0d end of source), checked %0d tokens",
               words_sent, eos_sent, tokens_checked);
      $display("covered keywords, dot words, numbers, strings, comments and operators");
      if (mismatches == 0)
         $display("fortran_subset_tokenizer_unit verification clean");
      else
         $display("fortran_subset_tokenizer_unit verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #(PERIOD * 300000);
      $display("fortran_subset_tokenizer_unit verification failed");
      $finish;
   end

endmodule
